// ===== hw/rtl/float_format_converter_defines.svh =====
// ----------------------------------------------------------------------------
// Float format converter assertion macros
// Shared helpers for concurrent assertions in the converter RTL.
// ----------------------------------------------------------------------------
`ifndef FLOAT_FORMAT_CONVERTER_DEFINES_SVH
`define FLOAT_FORMAT_CONVERTER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FFC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// Float format converter package
// Conversion kinds and special-value constants shared by the converter RTL.
// ----------------------------------------------------------------------------
package ffc_pkg;

  typedef enum logic [1:0] {
    KIND_H2S = 2'd0,
    KIND_S2H = 2'd1,
    KIND_B2S = 2'd2,
    KIND_S2B = 2'd3
  } kind_t;

  localparam logic [31:0] SINGLE_QNAN_NEG = 32'hFFC0_0000;
  localparam logic [15:0] HALF_NAN        = 16'h7FFF;
  localparam logic [15:0] HALF_INF        = 16'h7C00;

endpackage

// ===== hw/rtl/float_format_converter.sv =====
// ----------------------------------------------------------------------------
// Float format converter
// Converts between binary32 and binary16 / bfloat16, one operand per beat.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  input   | in_valid, in_stall, kind, operand_bits   | into block
//  output  | out_valid, out_stall, result_bits        | out of block
//
// One beat is accepted every cycle while in_stall is low; the result is registered and appears the cycle after.
// The only storage is the output register; the conversion is one pass of
// combinational logic between the input ports and that register.
// in_stall follows out_stall only while the output register is full.
// rst clears out_valid synchronously.
`include "float_format_converter_defines.svh"

module float_format_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits
);

  logic        out_valid_next;
  logic [31:0] conv;
  logic        accept;

  // Half to single.
  logic        hs;
  logic [4:0]  he;
  logic [9:0]  hf;
  logic [3:0]  lz;
  logic [31:0] h2s;
  logic [9:0]  hf_norm;

  // Single to half.
  logic        ss;
  logic [7:0]  se;
  logic [22:0] sm;
  logic [15:0] s2h;
  logic [14:0] nv;
  logic [12:0] nrem;
  logic [15:0] nv_r;
  logic [4:0]  sh;
  logic [23:0] mant;
  logic [23:0] sub_v;
  logic [23:0] sub_rem;
  logic [23:0] sub_half;
  logic [23:0] sub_mask;
  logic [10:0] sub_r;

  // Single to brain.
  logic [15:0] s2b;
  logic [7:0]  bq;
  logic [15:0] brem;
  logic [15:0] bsum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  // Binary16 to binary32, with a leading-one search for subnormals.
  always_comb begin
    hs = operand_bits[15];
    he = operand_bits[14:10];
    hf = operand_bits[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hf[i]) begin
        lz = 4'(i);
      end
    end
    hf_norm = 10'(hf << (4'd10 - lz));
    if (he == 5'd31) begin
      h2s = (hf != 10'd0) ? ffc_pkg::SINGLE_QNAN_NEG : {hs, 8'hFF, 23'd0};
    end else if (he == 5'd0) begin
      if (hf == 10'd0) begin
        h2s = {hs, 31'd0};
      end else begin
        h2s = {hs, 8'(lz) + 8'd103, hf_norm, 13'd0};
      end
    end else begin
      h2s = {hs, 8'(he) + 8'd112, hf, 13'd0};
    end
  end

  // Binary32 to binary16, round to nearest even.
  always_comb begin
    ss       = operand_bits[31];
    se       = operand_bits[30:23];
    sm       = operand_bits[22:0];
    nv       = {5'(se - 8'd112), sm[22:13]};
    nrem     = sm[12:0];
    nv_r     = {1'b0, nv};
    if (nrem > 13'h1000 || (nrem == 13'h1000 && nv[0])) begin
      nv_r = nv_r + 16'd1;
    end
    sh       = 5'(8'd126 - se);
    mant     = {1'b1, sm};
    sub_v    = mant >> sh;
    sub_mask = (24'd1 << sh) - 24'd1;
    sub_rem  = mant & sub_mask;
    sub_half = 24'd1 << (sh - 5'd1);
    sub_r    = sub_v[10:0];
    if (sub_rem > sub_half || (sub_rem == sub_half && sub_v[0])) begin
      sub_r = sub_r + 11'd1;
    end
    if (se == 8'hFF) begin
      s2h = (sm != 23'd0) ? ffc_pkg::HALF_NAN : {ss, 15'd0} | ffc_pkg::HALF_INF;
    end else if (se == 8'd0) begin
      s2h = {ss, 15'd0};
    end else if (se >= 8'd143) begin
      s2h = {ss, 15'd0} | ffc_pkg::HALF_INF;
    end else if (se >= 8'd113) begin
      s2h = (nv_r >= 16'h7C00) ? ({ss, 15'd0} | ffc_pkg::HALF_INF)
                               : {ss, nv_r[14:0]};
    end else if (se < 8'd102) begin
      s2h = {ss, 15'd0};
    end else begin
      s2h = {ss, 4'd0, sub_r};
    end
  end

  // Binary32 to bfloat16, round to nearest even with carry into exponent.
  always_comb begin
    bq   = {1'b0, operand_bits[22:16]};
    brem = operand_bits[15:0];
    if (brem > 16'h8000 || (brem == 16'h8000 && bq[0])) begin
      bq = bq + 8'd1;
    end
    bsum = {operand_bits[31:23], 7'd0} + {8'd0, bq};
    if (operand_bits[30:23] == 8'hFF) begin
      s2b = (operand_bits[22:0] != 23'd0) ? ffc_pkg::HALF_NAN : operand_bits[31:16];
    end else if (operand_bits[30:23] == 8'd0) begin
      s2b = {operand_bits[31], 15'd0};
    end else begin
      s2b = bsum;
    end
  end

  // Kind select.
  always_comb begin
    case (ffc_pkg::kind_t'(kind))
      ffc_pkg::KIND_H2S: conv = h2s;
      ffc_pkg::KIND_S2H: conv = {16'd0, s2h};
      ffc_pkg::KIND_B2S: conv = {operand_bits[15:0], 16'd0};
      ffc_pkg::KIND_S2B: conv = {16'd0, s2b};
      default:           conv = h2s;
    endcase
  end

  assign out_valid_next = accept || (out_valid && out_stall);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (accept) begin
      result_bits <= conv;
    end
  end

  `FFC_ASSERT_NEXT(a_accept_gives_valid, clk, rst, accept, out_valid)
  `FFC_ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall,
                   out_valid && $stable(result_bits))
  `FFC_ASSERT_NEXT(a_half_upper_zero, clk, rst,
                   accept && (kind == ffc_pkg::KIND_S2H || kind == ffc_pkg::KIND_S2B),
                   result_bits[31:16] == 16'd0)
  `FFC_ASSERT_IMP(a_no_stall_when_empty, clk, rst, !out_valid, !in_stall)

endmodule
